// ===== sv/lbg_pkg.sv =====
// types and constants shared by the lorentz boost block
`timescale 1ns / 1ps
package lbg_pkg;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_ERR = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   localparam logic [1:0] CSR_BETA_X = 2'd0;
   localparam logic [1:0] CSR_BETA_Y = 2'd1;
   localparam logic [1:0] CSR_BETA_Z = 2'd2;

   typedef struct packed {
      logic signed [31:0] t_in;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] t_out;
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] z_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic              err;
      logic [63:0]       g;
      logic [2:0][63:0]  cv;
      logic [2:0][63:0]  dv;
      logic [2:0][31:0]  beta;
   } coef_type;

endpackage

// ===== sv/lorentz_boost_general.sv =====
// top level of the general lorentz boost pipeline
`timescale 1ns / 1ps
// Boosts one Q16.16 four-vector per clock once the velocity is set. A transaction is
// taken when start is high and busy is low, and its result is shown for one cycle with
// rsp_valid; the receiver cannot stall and need not. Each write to
// a velocity register starts a sequential coefficient unit (square sum, bit-serial
// square root, two 64-step restoring divisions, seven 31-step shift-add multiplies)
// that holds busy high while it runs; the wide per-vector products run as
// 32-bit partial products across two pipeline stages.
module lorentz_boost_general #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lbg_pkg::req_type req_data,
   output logic             rsp_valid,
   output lbg_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import lbg_pkg::*;

   localparam int SAT_W = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
   localparam logic signed [127:0] LIM = (128'sd1 <<< (SAT_W - 1)) - 128'sd1;

   coef_type coef;
   logic     accept;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   req_type                   r1_ff, r2_ff, r3_ff, r4_ff, r5_ff;
   logic signed [2:0][63:0]   bpp1_ff;
   logic signed [63:0]        u2_ff, bp2_ff;
   logic signed [127:0]       acc5_ff [4];
   rsp_type                   rsp_ff;

   logic signed [127:0] prod_t;
   logic signed [127:0] prod_c [3];
   logic signed [127:0] prod_d [3];
   logic signed [31:0]  comp4 [3];
   logic signed [31:0]  res [4];
   logic [3:0]          sat;

   lbg_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .busy      (busy)
   );

   assign accept = start && !busy;

   always_comb begin
      comp4[0] = r4_ff.x_in;
      comp4[1] = r4_ff.y_in;
      comp4[2] = r4_ff.z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff      <= req_data;
      bpp1_ff[0] <= 64'($signed(coef.beta[0]) * req_data.x_in);
      bpp1_ff[1] <= 64'($signed(coef.beta[1]) * req_data.y_in);
      bpp1_ff[2] <= 64'($signed(coef.beta[2]) * req_data.z_in);
      r2_ff      <= r1_ff;
      bp2_ff     <= bpp1_ff[0] + bpp1_ff[1] + bpp1_ff[2];
      u2_ff      <= (64'(r1_ff.t_in) <<< 30) + bpp1_ff[0] + bpp1_ff[1] + bpp1_ff[2];
      r3_ff      <= r2_ff;
      r4_ff      <= r3_ff;
      r5_ff      <= r4_ff;
      acc5_ff[0] <= prod_t;
      for (int i = 0; i < 3; i++) begin
         acc5_ff[i + 1] <= (128'(comp4[i]) <<< 60) + prod_c[i] + (prod_d[i] <<< 30);
      end
   end

   lbg_wmul u_mul_t (
      .clock (clock),
      .a     ($signed(coef.g)),
      .b     (u2_ff),
      .p     (prod_t)
   );

   for (genvar k = 0; k < 3; k++) begin : g_comp
      lbg_wmul u_mul_c (
         .clock (clock),
         .a     ($signed(coef.cv[k])),
         .b     (bp2_ff),
         .p     (prod_c[k])
      );
      lbg_wmul u_mul_d (
         .clock (clock),
         .a     ($signed(coef.dv[k])),
         .b     (64'(r2_ff.t_in)),
         .p     (prod_d[k])
      );
   end

   always_comb begin
      logic signed [127:0] rnd;
      for (int i = 0; i < 4; i++) begin
         rnd = (acc5_ff[i] + (128'sd1 <<< 59)) >>> 60;
         if (rnd > LIM) begin
            res[i] = 32'(LIM);
            sat[i] = 1'b1;
         end else if (rnd < -LIM - 128'sd1) begin
            res[i] = 32'(-LIM - 128'sd1);
            sat[i] = 1'b1;
         end else begin
            res[i] = 32'(rnd);
            sat[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (coef.err) begin
         rsp_ff.t_out  <= r5_ff.t_in;
         rsp_ff.x_out  <= r5_ff.x_in;
         rsp_ff.y_out  <= r5_ff.y_in;
         rsp_ff.z_out  <= r5_ff.z_in;
         rsp_ff.status <= STATUS_ERR;
      end else begin
         rsp_ff.t_out  <= res[0];
         rsp_ff.x_out  <= res[1];
         rsp_ff.y_out  <= res[2];
         rsp_ff.z_out  <= res[3];
         rsp_ff.status <= (|sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/lbg_coef.sv =====
// velocity registers and sequential unit that derives the boost coefficients
`timescale 1ns / 1ps
module lbg_coef (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output lbg_pkg::coef_type coef,
   output logic              busy
);
   import lbg_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SQ, S_CHK, S_SQRT, S_DIV, S_MUL, S_FIX
   } state_type;

   state_type        state_ff;
   logic [2:0][31:0] beta_ff;
   logic             err_ff;
   logic [61:0]      bsq_ff;
   logic [5:0]       cnt_ff;
   logic [2:0]       sel_ff;
   logic             phase_ff;
   logic [63:0]      r_ff, v_ff, bit_ff;
   logic [63:0]      num_ff, rem_ff, q_ff, den_ff;
   logic [95:0]      a_ff, acc_ff;
   logic [30:0]      m_ff;
   logic [63:0]      g_ff, g2_ff;
   logic [2:0][63:0] cv_ff, dv_ff;

   logic [31:0]         sq_mag;
   logic [31:0]         nxt_mag;
   logic [63:0]         sq_trial, sq_v, sq_r;
   logic [63:0]         dv_sh, dv_rem, dv_q;
   logic [1:0]          cur_b, nxt_b;
   logic [2:0]          nsel;
   logic                cur_neg;
   logic signed [127:0] prod_s;
   logic [63:0]         fixed, g2v, f_val;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   always_comb begin
      sq_mag   = mag32(beta_ff[cnt_ff[1:0]]);
      sq_trial = r_ff + bit_ff;
      if (v_ff >= sq_trial) begin
         sq_v = v_ff - sq_trial;
         sq_r = (r_ff >> 1) + bit_ff;
      end else begin
         sq_v = v_ff;
         sq_r = r_ff >> 1;
      end
      dv_sh = {rem_ff[62:0], num_ff[63]};
      if (dv_sh >= den_ff) begin
         dv_rem = dv_sh - den_ff;
         dv_q   = {q_ff[62:0], 1'b1};
      end else begin
         dv_rem = dv_sh;
         dv_q   = {q_ff[62:0], 1'b0};
      end
      f_val   = 64'h4000_0000 - dv_q;
      cur_b   = (sel_ff <= 3'd3) ? 2'(sel_ff - 3'd1) : 2'(sel_ff - 3'd4);
      cur_neg = (sel_ff != 3'd0) && beta_ff[cur_b][31];
      prod_s  = cur_neg ? (128'sd0 - $signed({32'd0, acc_ff})) : $signed({32'd0, acc_ff});
      fixed   = 64'(prod_s >>> 30);
      g2v     = (bsq_ff == 62'd0) ? 64'd0 : 64'(acc_ff >> 30);
      nsel    = sel_ff + 3'd1;
      nxt_b   = (nsel <= 3'd3) ? 2'(nsel - 3'd1) : 2'(nsel - 3'd4);
      nxt_mag = mag32(beta_ff[nxt_b]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         beta_ff  <= '0;
         err_ff   <= 1'b0;
         g_ff     <= 64'h4000_0000;
         cv_ff    <= '0;
         dv_ff    <= '0;
      end else if (csr_we && (csr_index == CSR_BETA_X || csr_index == CSR_BETA_Y ||
                              csr_index == CSR_BETA_Z)) begin
         beta_ff[csr_index] <= csr_wdata;
         state_ff <= S_SQ;
         cnt_ff   <= '0;
         bsq_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: ;
            S_SQ: begin
               if (sq_mag >= 32'h4000_0000)
                  err_ff <= 1'b1;
               else
                  bsq_ff <= bsq_ff + 62'(sq_mag[29:0] * sq_mag[29:0]);
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd2)
                  state_ff <= S_CHK;
            end
            S_CHK: begin
               if (err_ff || bsq_ff >= 62'h1000_0000_0000_0000) begin
                  err_ff   <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  v_ff     <= (64'h1000_0000_0000_0000 - {2'd0, bsq_ff}) << 2;
                  r_ff     <= '0;
                  bit_ff   <= 64'h4000_0000_0000_0000;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               v_ff   <= sq_v;
               r_ff   <= sq_r;
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 64'd1) begin
                  den_ff   <= sq_r;
                  num_ff   <= 64'h2000_0000_0000_0000;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == 6'd63) begin
                  rem_ff <= '0;
                  q_ff   <= '0;
                  cnt_ff <= '0;
                  if (!phase_ff) begin
                     g_ff     <= dv_q;
                     den_ff   <= dv_q + 64'h4000_0000;
                     num_ff   <= 64'h1000_0000_0000_0000;
                     phase_ff <= 1'b1;
                  end else begin
                     a_ff     <= {32'd0, g_ff};
                     m_ff     <= f_val[30:0];
                     acc_ff   <= '0;
                     sel_ff   <= '0;
                     state_ff <= S_MUL;
                  end
               end else begin
                  rem_ff <= dv_rem;
                  q_ff   <= dv_q;
                  num_ff <= num_ff << 1;
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_MUL: begin
               if (m_ff[0])
                  acc_ff <= acc_ff + a_ff;
               a_ff   <= a_ff << 1;
               m_ff   <= m_ff >> 1;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd30)
                  state_ff <= S_FIX;
            end
            S_FIX: begin
               if (sel_ff == 3'd0)
                  g2_ff <= g2v;
               else if (sel_ff <= 3'd3)
                  cv_ff[cur_b] <= fixed;
               else
                  dv_ff[cur_b] <= fixed;
               if (sel_ff == 3'd6) begin
                  state_ff <= S_IDLE;
               end else begin
                  sel_ff   <= nsel;
                  a_ff     <= {32'd0, (nsel == 3'd1) ? g2v : ((nsel <= 3'd3) ? g2_ff : g_ff)};
                  m_ff     <= nxt_mag[30:0];
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_MUL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign coef.err  = err_ff;
   assign coef.g    = g_ff;
   assign coef.cv   = cv_ff;
   assign coef.dv   = dv_ff;
   assign coef.beta = beta_ff;

endmodule

// ===== sv/lbg_wmul.sv =====
// two-stage signed 64 x 64 multiplier built from four partial products
`timescale 1ns / 1ps
module lbg_wmul (
   input  logic                clock,
   input  logic signed [63:0]  a,
   input  logic signed [63:0]  b,
   output logic signed [127:0] p
);
   logic signed [65:0]  pp_ff [4];
   logic signed [127:0] p_ff;

   always_ff @(posedge clock) begin
      pp_ff[0] <= 66'($signed({1'b0, a[31:0]}) * $signed({1'b0, b[31:0]}));
      pp_ff[1] <= 66'($signed({1'b0, a[31:0]}) * $signed(b[63:32]));
      pp_ff[2] <= 66'($signed(a[63:32]) * $signed({1'b0, b[31:0]}));
      pp_ff[3] <= 66'($signed(a[63:32]) * $signed(b[63:32]));
      p_ff <= 128'(pp_ff[0]) + (128'(pp_ff[1]) <<< 32) + (128'(pp_ff[2]) <<< 32)
            + (128'(pp_ff[3]) <<< 64);
   end

   assign p = p_ff;

endmodule

// ===== sv/lbg_check.sv =====
// port checker for the lorentz boost block and its bind
`timescale 1ns / 1ps
module lbg_check (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lbg_pkg::req_type req_data,
   input logic             rsp_valid,
   input lbg_pkg::rsp_type rsp_data,
   input logic             csr_we,
   input logic [1:0]       csr_index
);
   import lbg_pkg::*;

   a_rsp_follows_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without a transaction six cycles earlier");

   a_err_passes_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_ERR) |-> rsp_data.t_out == $past(req_data.t_in, 6))
      else $error("error result does not pass the time component");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_ERR ||
                     rsp_data.status == STATUS_SAT))
      else $error("undefined status code");

   a_write_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CSR_BETA_X || csr_index == CSR_BETA_Y ||
                  csr_index == CSR_BETA_Z)) |=> busy)
      else $error("velocity write did not start the coefficient unit");

endmodule

bind lorentz_boost_general lbg_check u_lbg_check (.*);
